@@ sv/rsg_pkg.sv @@
// Shared constants and types of the ring span generator.
package rsg_pkg;

   // Register indexes of the configuration port (byte address is 4 * index).
   localparam int unsigned REG_IDX_BITS = 3;
   localparam logic [REG_IDX_BITS-1:0] REG_CENTER_X     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Y     = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_OUTER_RADIUS = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_THICKNESS    = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_COLOR        = 3'd4;

   localparam int unsigned CSR_ADDR_BITS = REG_IDX_BITS + 2;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned COLOR_BITS    = 32;

   // Eight mirrored spans per step.
   localparam int unsigned SPANS_PER_STEP = 8;
   localparam int unsigned SPAN_IDX_BITS  = $clog2(SPANS_PER_STEP);
   localparam logic [SPAN_IDX_BITS-1:0] SPAN_LAST = SPAN_IDX_BITS'(SPANS_PER_STEP - 1);

   // Per span: bit set where the row offset is subtracted from the fixed coordinate.
   localparam logic [SPANS_PER_STEP-1:0] SPAN_Y_NEG  = 8'b0111_1000;
   // Per span: bit set where the span runs from center - outer to center - inner.
   localparam logic [SPANS_PER_STEP-1:0] SPAN_MIRROR = 8'b1011_0100;

   // Control passed from the walker into the span emitter with one step.
   typedef struct packed {
      logic load;   // a productive step enters the emitter
      logic done;   // the walk ends with this step
   } step_ctrl_type;

endpackage

@@ sv/rsg_csr.sv @@
// Configuration registers of the ring span generator behind an APB-style port.
module rsg_csr #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rsg_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [rsg_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [rsg_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output logic [COORD_BITS-1:0]                center_x,
   output logic [COORD_BITS-1:0]                center_y,
   output logic [COORD_BITS-2:0]                outer_radius,
   output logic [COORD_BITS-2:0]                thickness,
   output logic [rsg_pkg::COLOR_BITS-1:0]       color
);
   import rsg_pkg::*;

   logic [COORD_BITS-1:0]        center_x_ff;
   logic [COORD_BITS-1:0]        center_y_ff;
   logic [COORD_BITS-2:0]        outer_radius_ff;
   logic [COORD_BITS-2:0]        thickness_ff;
   logic [COLOR_BITS-1:0]        color_ff;
   logic                         wr_en;
   logic [REG_IDX_BITS-1:0]      reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         outer_radius_ff <= '0;
         thickness_ff    <= '0;
         color_ff        <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_CENTER_X:     center_x_ff     <= pwdata[COORD_BITS-1:0];
            REG_CENTER_Y:     center_y_ff     <= pwdata[COORD_BITS-1:0];
            REG_OUTER_RADIUS: outer_radius_ff <= pwdata[COORD_BITS-2:0];
            REG_THICKNESS:    thickness_ff    <= pwdata[COORD_BITS-2:0];
            REG_COLOR:        color_ff        <= pwdata[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CENTER_X:     prdata = CSR_DATA_BITS'(center_x_ff);
         REG_CENTER_Y:     prdata = CSR_DATA_BITS'(center_y_ff);
         REG_OUTER_RADIUS: prdata = CSR_DATA_BITS'(outer_radius_ff);
         REG_THICKNESS:    prdata = CSR_DATA_BITS'(thickness_ff);
         REG_COLOR:        prdata = CSR_DATA_BITS'(color_ff);
         default:          prdata = '0;
      endcase
   end

   assign center_x     = center_x_ff;
   assign center_y     = center_y_ff;
   assign outer_radius = outer_radius_ff;
   assign thickness    = thickness_ff;
   assign color        = color_ff;

endmodule

@@ sv/rsg_walker.sv @@
// Coupled midpoint walks of the outer and inner ring edges, one step per tick.
module rsg_walker #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick,
   input  logic                          restart,
   input  logic [COORD_BITS-2:0]         outer_radius,
   input  logic [COORD_BITS-2:0]         thickness,
   output rsg_pkg::step_ctrl_type        step_ctrl,
   output logic signed [COORD_BITS:0]    step_xo,
   output logic signed [COORD_BITS:0]    step_xi,
   output logic signed [COORD_BITS:0]    step_y
);
   import rsg_pkg::*;

   localparam int unsigned PW = COORD_BITS + 1;  // edge and row positions
   localparam int unsigned EW = COORD_BITS + 2;  // saturated error terms
   localparam int unsigned SW = COORD_BITS + 4;  // error sums before saturation

   function automatic logic signed [EW-1:0] sat_err(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = {{(SW-EW+1){1'b0}}, {(EW-1){1'b1}}};
      lo = ~hi;
      if (v > hi)      sat_err = hi[EW-1:0];
      else if (v < lo) sat_err = lo[EW-1:0];
      else             sat_err = v[EW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] ext_pos(input logic signed [PW-1:0] p);
      ext_pos = {{(SW-PW){p[PW-1]}}, p};
   endfunction

   function automatic logic signed [SW-1:0] ext_err(input logic signed [EW-1:0] e);
      ext_err = {{(SW-EW){e[EW-1]}}, e};
   endfunction

   logic signed [PW-1:0] xo_ff, xo_in;
   logic signed [PW-1:0] xi_ff, xi_in;
   logic signed [PW-1:0] y_ff, y_in;
   logic signed [PW-1:0] ir_ff, ir_in;
   logic signed [EW-1:0] eo_ff, eo_in;
   logic signed [EW-1:0] ei_ff, ei_in;
   logic                 walking_ff, walking_in;

   logic signed [PW-1:0] ir_load, xo_load;
   logic signed [PW-1:0] xo_cur, xi_cur, y_cur, ir_cur, y_nxt, xo_dec, xi_dec;
   logic signed [EW-1:0] eo_cur, ei_cur;
   logic                 walk_cur, emit;

   always_comb begin
      xo_load = {2'b00, outer_radius};
      ir_load = {2'b00, outer_radius} - {2'b00, thickness};

      // Reload from the registers on restart, then step from there.
      xo_cur   = restart ? xo_load : xo_ff;
      xi_cur   = restart ? ir_load : xi_ff;
      y_cur    = restart ? '0      : y_ff;
      ir_cur   = restart ? ir_load : ir_ff;
      eo_cur   = restart ? sat_err(SW'(1) - ext_pos(xo_load)) : eo_ff;
      ei_cur   = restart ? sat_err(SW'(1) - ext_pos(ir_load)) : ei_ff;
      walk_cur = restart | walking_ff;
      emit     = walk_cur && !(xo_cur < y_cur);

      y_nxt  = y_cur + PW'(1);
      xo_dec = xo_cur - PW'(1);
      xi_dec = xi_cur - PW'(1);

      xo_in = xo_cur;
      xi_in = xi_cur;
      y_in  = y_cur;
      ir_in = ir_cur;
      eo_in = eo_cur;
      ei_in = ei_cur;
      walking_in = 1'b0;

      if (emit) begin
         y_in = y_nxt;
         if (eo_cur[EW-1]) begin
            eo_in = sat_err(ext_err(eo_cur) + (ext_pos(y_nxt) <<< 1) + SW'(1));
         end else begin
            xo_in = xo_dec;
            eo_in = sat_err(ext_err(eo_cur)
                            + ((ext_pos(y_nxt) - ext_pos(xo_dec) + SW'(1)) <<< 1));
         end
         // Clamp the inner edge to the row once the row passes the inner radius.
         if (y_nxt > ir_cur) begin
            xi_in = y_nxt;
         end else if (ei_cur[EW-1]) begin
            ei_in = sat_err(ext_err(ei_cur) + (ext_pos(y_nxt) <<< 1) + SW'(1));
         end else begin
            xi_in = xi_dec;
            ei_in = sat_err(ext_err(ei_cur)
                            + ((ext_pos(y_nxt) - ext_pos(xi_dec) + SW'(1)) <<< 1));
         end
         walking_in = !(xo_in < y_nxt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xo_ff      <= '0;
         xi_ff      <= '0;
         y_ff       <= '0;
         ir_ff      <= '0;
         eo_ff      <= '0;
         ei_ff      <= '0;
         walking_ff <= 1'b0;
      end else if (tick) begin
         xo_ff      <= xo_in;
         xi_ff      <= xi_in;
         y_ff       <= y_in;
         ir_ff      <= ir_in;
         eo_ff      <= eo_in;
         ei_ff      <= ei_in;
         walking_ff <= walking_in;
      end
   end

   assign step_ctrl.load = tick & emit;
   assign step_ctrl.done = ~walking_in;
   assign step_xo = xo_cur;
   assign step_xi = xi_cur;
   assign step_y  = y_cur;

   // A running walk never has the outer edge below the row offset.
   a_walk_edge: assert property (@(posedge clock) disable iff (reset)
      walking_ff |-> !(xo_ff < y_ff))
      else $error("walker: walking with outer edge below row");

   // A restart tick always produces a step.
   a_restart_emits: assert property (@(posedge clock) disable iff (reset)
      (tick && restart) |-> step_ctrl.load)
      else $error("walker: restart tick produced no step");

   // Once idle, a tick without restart leaves the walk idle.
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (tick && !restart && !walking_ff) |=> !walking_ff)
      else $error("walker: idle walk resumed without restart");

endmodule

@@ sv/rsg_emitter.sv @@
// Step buffer and span sequencer: turns one step into eight registered span beats.
module rsg_emitter #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rsg_pkg::step_ctrl_type              step_ctrl,
   input  logic signed [COORD_BITS:0]          step_xo,
   input  logic signed [COORD_BITS:0]          step_xi,
   input  logic signed [COORD_BITS:0]          step_y,
   output logic                                step_free,
   input  logic [COORD_BITS-1:0]               center_x,
   input  logic [COORD_BITS-1:0]               center_y,
   input  logic [rsg_pkg::COLOR_BITS-1:0]      color,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_vertical,
   output logic signed [COORD_BITS+1:0]        rsp_fixed_coord,
   output logic signed [COORD_BITS+1:0]        rsp_span_start,
   output logic signed [COORD_BITS+1:0]        rsp_span_end,
   output logic [rsg_pkg::COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                                rsp_last_span,
   output logic                                rsp_ring_done
);
   import rsg_pkg::*;

   localparam int unsigned PW = COORD_BITS + 1;
   localparam int unsigned OW = COORD_BITS + 2;

   logic                      busy_ff, busy_in;
   logic [SPAN_IDX_BITS-1:0]  cnt_ff, cnt_in;
   logic signed [PW-1:0]      xo_ff, xi_ff, y_ff;
   logic                      done_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      vert_ff, last_ff, ring_done_ff;
   logic signed [OW-1:0]      fixed_ff, start_ff, end_ff;
   logic [COLOR_BITS-1:0]     color_ff;

   logic                      out_load, step_end;
   logic                      vert_w;
   logic signed [OW-1:0]      base_fix, base_rng, xo_e, xi_e, y_e;
   logic signed [OW-1:0]      fixed_w, start_w, end_w;

   assign out_load  = busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign step_end  = out_load & (cnt_ff == SPAN_LAST);
   assign step_free = ~busy_ff | step_end;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (out_load) begin
         cnt_in = cnt_ff + SPAN_IDX_BITS'(1);
      end
      if (step_end) begin
         busy_in = 1'b0;
      end
      if (step_ctrl.load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
      rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   end

   // Mirror the current step into the octant selected by the span counter.
   always_comb begin
      vert_w   = cnt_ff[0];
      xo_e     = {xo_ff[PW-1], xo_ff};
      xi_e     = {xi_ff[PW-1], xi_ff};
      y_e      = {y_ff[PW-1], y_ff};
      base_fix = vert_w ? {2'b00, center_x} : {2'b00, center_y};
      base_rng = vert_w ? {2'b00, center_y} : {2'b00, center_x};
      fixed_w  = SPAN_Y_NEG[cnt_ff] ? base_fix - y_e : base_fix + y_e;
      if (SPAN_MIRROR[cnt_ff]) begin
         start_w = base_rng - xo_e;
         end_w   = base_rng - xi_e;
      end else begin
         start_w = base_rng + xi_e;
         end_w   = base_rng + xo_e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_ctrl.load) begin
         xo_ff   <= step_xo;
         xi_ff   <= step_xi;
         y_ff    <= step_y;
         done_ff <= step_ctrl.done;
      end
      if (out_load) begin
         vert_ff      <= vert_w;
         fixed_ff     <= fixed_w;
         start_ff     <= start_w;
         end_ff       <= end_w;
         color_ff     <= color;
         last_ff      <= (cnt_ff == SPAN_LAST);
         ring_done_ff <= (cnt_ff == SPAN_LAST) & done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertical    = vert_ff;
   assign rsp_fixed_coord = fixed_ff;
   assign rsp_span_start  = start_ff;
   assign rsp_span_end    = end_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_last_span   = last_ff;
   assign rsp_ring_done   = ring_done_ff;

   // A new step only enters an empty buffer or one whose last span leaves now.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step_ctrl.load |-> step_free)
      else $error("emitter: step buffer overwritten");

   // Ring done is only ever flagged on the last span of a step.
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ring_done_ff) |-> last_ff)
      else $error("emitter: ring done without last span");

   // Handing out the eighth span marks it last.
   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      step_end |=> (rsp_valid_ff && last_ff))
      else $error("emitter: eighth span not marked last");

endmodule

@@ sv/ring_span_generator.sv @@
// Top level of the ring span generator: thick circle outline to span beats.
//
//   channel  | direction | handshake            | beat payload
//   ---------+-----------+----------------------+-----------------------------------------
//   req      | in        | req_valid/req_stall  | restart
//   rsp      | out       | rsp_valid/rsp_stall  | vertical, fixed_coord, span_start,
//            |           |                      | span_end, pixel_color, last_span, ring_done
//   csr      | in        | psel/penable/pready  | paddr, pwdata, prdata (5 registers)
//
// A req beat is stepped by the edge walker in the cycle it is accepted. A productive
// step yields eight rsp beats, one per cycle from the span sequencer while rsp_stall
// is low, so the single rsp port sets how fast req beats are taken. The first span
// passes the step buffer, then the rsp register. A tick without spans loads no step.
// The next req beat is taken in the cycle the eighth span enters the rsp register.
// Reset is synchronous and clears the walk, sequencer and registers; no clearing pass.
// A stall on rsp holds the current span and backs up into req_stall.
module ring_span_generator #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_vertical,
   output logic signed [COORD_BITS+1:0]         rsp_fixed_coord,
   output logic signed [COORD_BITS+1:0]         rsp_span_start,
   output logic signed [COORD_BITS+1:0]         rsp_span_end,
   output logic [rsg_pkg::COLOR_BITS-1:0]       rsp_pixel_color,
   output logic                                 rsp_last_span,
   output logic                                 rsp_ring_done,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rsg_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [rsg_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [rsg_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);
   import rsg_pkg::*;

   logic [COORD_BITS-1:0]     center_x;
   logic [COORD_BITS-1:0]     center_y;
   logic [COORD_BITS-2:0]     outer_radius;
   logic [COORD_BITS-2:0]     thickness;
   logic [COLOR_BITS-1:0]     color;

   step_ctrl_type             step_ctrl;
   logic signed [COORD_BITS:0] step_xo, step_xi, step_y;
   logic                      step_free;
   logic                      tick;

   // Hold req while the sequencer still has spans of the previous step to hand out.
   assign req_stall = ~step_free;
   assign tick      = req_valid & step_free;

   rsg_csr #(
      .COORD_BITS(COORD_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .center_x     (center_x),
      .center_y     (center_y),
      .outer_radius (outer_radius),
      .thickness    (thickness),
      .color        (color)
   );

   // Advance both edge walks on every accepted tick.
   rsg_walker #(
      .COORD_BITS(COORD_BITS)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .tick         (tick),
      .restart      (req_restart),
      .outer_radius (outer_radius),
      .thickness    (thickness),
      .step_ctrl    (step_ctrl),
      .step_xo      (step_xo),
      .step_xi      (step_xi),
      .step_y       (step_y)
   );

   // Mirror each step into eight registered span beats.
   rsg_emitter #(
      .COORD_BITS(COORD_BITS)
   ) u_emitter (
      .clock           (clock),
      .reset           (reset),
      .step_ctrl       (step_ctrl),
      .step_xo         (step_xo),
      .step_xi         (step_xi),
      .step_y          (step_y),
      .step_free       (step_free),
      .center_x        (center_x),
      .center_y        (center_y),
      .color           (color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vertical    (rsp_vertical),
      .rsp_fixed_coord (rsp_fixed_coord),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_end    (rsp_span_end),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_span   (rsp_last_span),
      .rsp_ring_done   (rsp_ring_done)
   );

endmodule
